// ----- hdl/rpc_pkg.sv -----
package rpc_pkg;

  // Printable alphabet: the 89 codes from '!' up to 'y'.
  localparam int unsigned ALPHA_SIZE   = 89;
  localparam int unsigned ALPHA_LOW    = 33;
  localparam int unsigned ALPHA_HIGH   = 121;
  localparam int unsigned INVALID_CHAR = 33;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned MAX_ROTORS = 4;
  // Wide enough for MAX_ROTORS positions of at most ALPHA_SIZE - 1 each.
  localparam int unsigned SUM_W      = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_ENCRYPT_MODE  = 3'd0;
  localparam cfg_idx_t REG_ROTOR_START_0 = 3'd1;
  localparam cfg_idx_t REG_ROTOR_START_1 = 3'd2;
  localparam cfg_idx_t REG_ROTOR_START_2 = 3'd3;
  localparam cfg_idx_t REG_ROTOR_START_3 = 3'd4;

  localparam pos_t  POS_LAST     = pos_t'(ALPHA_SIZE - 1);
  localparam pos_t  POS_MOD      = pos_t'(ALPHA_SIZE);
  localparam char_t CHAR_LOW     = char_t'(ALPHA_LOW);
  localparam char_t CHAR_HIGH    = char_t'(ALPHA_HIGH);
  localparam char_t CHAR_INVALID = char_t'(INVALID_CHAR);

  // Controls from the input handshake to the rotor bank.
  typedef struct packed {
    logic advance;  // a word is accepted this cycle
    logic reload;   // load start positions before ciphering it
  } rotor_ctl_t;

endpackage

// ----- hdl/rotor_printable_cipher_core.sv -----
// A result word is registered in stage one at its input handshake and then in the output
// register, where it waits until it is taken.
// Throughput: one word per cycle. The rotors step at the input handshake, so no bubble
// is needed between words. A waiting result blocks intake once stage one is also full.
// Reset (rst, synchronous, active high): rotors at zero, encrypt mode on, start
// positions zero, both pipeline stages empty.
module rotor_printable_cipher_core #(
  parameter int ROTORS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rpc_pkg::cfg_idx_t   cfg_index,
  input  rpc_pkg::cfg_data_t  cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpc_pkg::char_t      in_char,
  input  logic                message_start,
  output logic                out_valid,
  input  logic                out_ready,
  output rpc_pkg::char_t      out_char,
  output logic                out_invalid
);
  import rpc_pkg::*;

  // Configuration registers. The user must change them only while the core is idle
  // (the block does not enforce this), so both pipeline stages read them directly.
  logic encrypt_mode;
  pos_t rotor_start [MAX_ROTORS];

  // Stage one holds the accepted word with the rotor sum it was ciphered
  // against; the output register holds the finished word.
  logic s1_valid;
  pos_t s1_idx;
  logic s1_invalid;
  pos_t s1_sum;

  logic       in_fire;
  logic       s1_move;
  logic       out_load;
  logic       in_bad;
  rotor_ctl_t rotor_ctl;
  pos_t       pos_sum;
  char_t      result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      encrypt_mode <= 1'b1;
      for (int k = 0; k < MAX_ROTORS; k++) begin
        rotor_start[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENCRYPT_MODE:  encrypt_mode   <= cfg_data[0];
        REG_ROTOR_START_0: rotor_start[0] <= cfg_data;
        REG_ROTOR_START_1: rotor_start[1] <= cfg_data;
        REG_ROTOR_START_2: rotor_start[2] <= cfg_data;
        REG_ROTOR_START_3: rotor_start[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The output register loads when it is empty or its word is being taken.
  // Stage one accepts a new word whenever it is empty or drains this cycle,
  // so intake continues while a result waits, as long as stage one is empty.
  assign out_load = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;
  assign in_fire  = in_valid && in_ready;

  assign rotor_ctl.advance = in_fire;
  assign rotor_ctl.reload  = message_start;

  // Rotor positions, reload on message start, and the odometer step.
  rpc_rotor_bank #(
    .ROTORS (ROTORS)
  ) u_rotor_bank (
    .clk         (clk),
    .rst         (rst),
    .ctl         (rotor_ctl),
    .rotor_start (rotor_start),
    .pos_sum     (pos_sum)
  );

  assign in_bad = (in_char < CHAR_LOW) || (in_char > CHAR_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx     <= pos_t'(in_char - CHAR_LOW);
      s1_invalid <= in_bad;
      s1_sum     <= pos_sum;
    end
  end

  // Modular shift of the alphabet index; invalid words become '!'.
  rpc_cipher_math u_cipher_math (
    .idx     (s1_idx),
    .pos_sum (s1_sum),
    .encrypt (encrypt_mode),
    .invalid (s1_invalid),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_char    <= result;
      out_invalid <= s1_invalid;
    end
  end

`ifndef SYNTHESIS
  // A valid result always lies in the alphabet.
  a_out_in_alphabet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char >= CHAR_LOW) && (out_char <= CHAR_HIGH))
    else $error("result word outside the printable alphabet");

  // An invalid input always reports as the exclamation mark.
  a_invalid_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_invalid) |-> (out_char == CHAR_INVALID))
    else $error("invalid word not replaced by the marker character");

  // The stored rotor sum is always reduced.
  a_sum_reduced: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_sum < POS_MOD))
    else $error("rotor sum not reduced below the alphabet size");

  // A word in stage one reaches the output when the output is free.
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_load) |=> out_valid)
    else $error("stage one word lost on its way to the output");
`endif

endmodule

// ----- hdl/rpc_rotor_bank.sv -----
module rpc_rotor_bank #(
  parameter int ROTORS = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rpc_pkg::rotor_ctl_t  ctl,
  input  rpc_pkg::pos_t        rotor_start [rpc_pkg::MAX_ROTORS],
  output rpc_pkg::pos_t        pos_sum
);
  import rpc_pkg::*;

  localparam int NROT = (ROTORS < 1) ? 1 : ((ROTORS > 4) ? 4 : ROTORS);

  pos_t pos      [NROT];
  pos_t pos_next [NROT];
  pos_t pos_used [NROT];
  sum_t raw_sum;
  logic carry;

  // Positions that cipher the current word, and the odometer step after it.
  always_comb begin
    carry   = 1'b1;
    raw_sum = '0;
    for (int k = 0; k < NROT; k++) begin
      if (ctl.reload) begin
        pos_used[k] = (rotor_start[k] >= POS_MOD) ? rotor_start[k] - POS_MOD
                                                   : rotor_start[k];
      end else begin
        pos_used[k] = pos[k];
      end
      raw_sum = raw_sum + sum_t'(pos_used[k]);
      if (carry) begin
        if (pos_used[k] == POS_LAST) begin
          pos_next[k] = '0;
        end else begin
          pos_next[k] = pos_used[k] + pos_t'(1);
          carry       = 1'b0;
        end
      end else begin
        pos_next[k] = pos_used[k];
      end
    end
  end

  // The raw sum stays below four times the alphabet size.
  always_comb begin
    if (raw_sum >= sum_t'(3 * ALPHA_SIZE)) begin
      pos_sum = pos_t'(raw_sum - sum_t'(3 * ALPHA_SIZE));
    end else if (raw_sum >= sum_t'(2 * ALPHA_SIZE)) begin
      pos_sum = pos_t'(raw_sum - sum_t'(2 * ALPHA_SIZE));
    end else if (raw_sum >= sum_t'(ALPHA_SIZE)) begin
      pos_sum = pos_t'(raw_sum - sum_t'(ALPHA_SIZE));
    end else begin
      pos_sum = pos_t'(raw_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NROT; k++) begin
        pos[k] <= '0;
      end
    end else if (ctl.advance) begin
      for (int k = 0; k < NROT; k++) begin
        pos[k] <= pos_next[k];
      end
    end
  end

endmodule

// ----- hdl/rpc_cipher_math.sv -----
module rpc_cipher_math (
  input  rpc_pkg::pos_t  idx,
  input  rpc_pkg::pos_t  pos_sum,
  input  logic           encrypt,
  input  logic           invalid,
  output rpc_pkg::char_t result
);
  import rpc_pkg::*;

  char_t shift2;
  pos_t  shift;
  char_t mixed;
  pos_t  res;

  always_comb begin
    // Forward and back through every rotor doubles the shift.
    shift2 = {pos_sum, 1'b0};
    shift  = (shift2 >= char_t'(ALPHA_SIZE)) ? pos_t'(shift2 - char_t'(ALPHA_SIZE))
                                             : pos_t'(shift2);
    if (encrypt) begin
      mixed = char_t'(idx) + char_t'(shift);
    end else begin
      mixed = char_t'(idx) + char_t'(ALPHA_SIZE) - char_t'(shift);
    end
    res = (mixed >= char_t'(ALPHA_SIZE)) ? pos_t'(mixed - char_t'(ALPHA_SIZE))
                                         : pos_t'(mixed);
    result = invalid ? CHAR_INVALID : char_t'(res) + CHAR_LOW;
  end

endmodule

// ----- tb/rotor_printable_cipher_core_tb.sv -----
`timescale 1ns / 1ps

module rotor_printable_cipher_core_tb;

  import rpc_pkg::*;

  // The block is built with its default rotor count. The predictor clamps it the same
  // way the hardware does, so a change here keeps the two in step.
  localparam int ROTOR_COUNT = 3;
  localparam int LIVE_ROTORS = (ROTOR_COUNT < 1) ? 1 : ((ROTOR_COUNT > 4) ? 4 : ROTOR_COUNT);

  // Longest run of cycles with no handshake on any channel before the run is declared hung.
  localparam int STALL_LIMIT = 1000;

  // A word waiting to be sent. When drain is set, the sender holds this word back
  // until every earlier word has come out of the block.
  typedef struct packed {
    char_t ch;
    logic  reload;
    logic  drain;
  } plain_word_t;

  // One ciphered word as the block should return it.
  typedef struct packed {
    char_t ch;
    logic  invalid;
  } cipher_word_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = REG_ENCRYPT_MODE;
  cfg_data_t cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  char_t     in_char = '0;
  logic      message_start = 1'b0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  char_t     out_char;
  logic      out_invalid;

  rotor_printable_cipher_core #(
    .ROTORS(ROTOR_COUNT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .message_start(message_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_invalid  (out_invalid)
  );

  always #5 clk = ~clk;

  // Shadow copy of the cipher: configuration registers and the rotor odometer.
  logic         shadow_encrypt = 1'b1;
  pos_t         shadow_start[4] = '{default: '0};
  pos_t         shadow_spin[4] = '{default: '0};

  plain_word_t  plain_pending[$];
  cipher_word_t cipher_due[$];

  // Word counters. All but words_queued only change at the rising edge, so the processes
  // that run at the falling edge can read them without racing the monitor.
  int unsigned  words_queued = 0;
  int unsigned  words_accepted = 0;
  int unsigned  words_checked = 0;
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;

  // Handshake flags captured at the rising edge for the drivers at the falling edge.
  bit           in_taken = 1'b0;
  bit           out_taken = 1'b0;
  int           in_hold = 0;
  int           out_hold = 0;
  bit           in_calm = 1'b0;
  bit           out_calm = 1'b0;

  // Mirror of a register write into the shadow configuration.
  function automatic void shadow_write(input cfg_idx_t idx, input cfg_data_t val);
    case (idx)
      REG_ENCRYPT_MODE:  shadow_encrypt = val[0];
      REG_ROTOR_START_0: shadow_start[0] = pos_t'(val);
      REG_ROTOR_START_1: shadow_start[1] = pos_t'(val);
      REG_ROTOR_START_2: shadow_start[2] = pos_t'(val);
      REG_ROTOR_START_3: shadow_start[3] = pos_t'(val);
      default: ;
    endcase
  endfunction

  // Cipher one accepted word and step the odometer. The word is ciphered with the
  // positions in force before the step, after an optional reload from the start
  // registers. Start values at or above the alphabet size are reduced on load, and a
  // carry out of the slowest rotor is dropped so the odometer wraps to all zero.
  function automatic cipher_word_t cipher_predict(input char_t ch, input logic reload);
    cipher_word_t res;
    int unsigned  total;
    int unsigned  shift;
    int unsigned  idx;
    logic         carry;
    if (reload) begin
      for (int k = 0; k < 4; k++) begin
        shadow_spin[k] = (k < LIVE_ROTORS) ? pos_t'(int'(shadow_start[k]) % ALPHA_SIZE) : '0;
      end
    end
    if (ch < CHAR_LOW || ch > CHAR_HIGH) begin
      // Bytes outside the printable alphabet come back as '!' with the flag set,
      // but they still turn the rotors.
      res.ch = CHAR_INVALID;
      res.invalid = 1'b1;
    end else begin
      total = 0;
      for (int k = 0; k < LIVE_ROTORS; k++) begin
        total += shadow_spin[k];
      end
      // Each rotor is crossed on the way in and again on the way back.
      shift = (2 * total) % ALPHA_SIZE;
      idx = int'(ch) - ALPHA_LOW;
      if (shadow_encrypt) begin
        idx = (idx + shift) % ALPHA_SIZE;
      end else begin
        idx = (idx + ALPHA_SIZE - shift) % ALPHA_SIZE;
      end
      res.ch = char_t'(idx + ALPHA_LOW);
      res.invalid = 1'b0;
    end
    carry = 1'b1;
    for (int k = 0; k < LIVE_ROTORS; k++) begin
      if (carry) begin
        if (shadow_spin[k] == POS_LAST) begin
          shadow_spin[k] = '0;
        end else begin
          shadow_spin[k] = shadow_spin[k] + pos_t'(1);
          carry = 1'b0;
        end
      end
    end
    return res;
  endfunction

  // Wait before the next word on one side: none during a calm stretch, otherwise
  // a wait drawn uniformly at random.
  function automatic int draw_wait(input bit calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Rising edge: every handshake is seen here. Accepted input words are ciphered by
  // the shadow model at once, and accepted result words are checked against the
  // oldest word still due. The watchdog lives here as well.
  always @(posedge clk) begin : observe
    cipher_word_t want;
    in_taken = !rst && in_valid && in_ready;
    out_taken = !rst && out_valid && out_ready;
    if (in_taken) begin
      cipher_due = {cipher_due, cipher_predict(in_char, message_start)};
      words_accepted++;
    end
    if (out_taken) begin
      if (cipher_due.size() == 0) begin
        $display("%0t: result word with none due: out_char %0d out_invalid %0b",
                 $time, out_char, out_invalid);
        errors++;
      end else begin
        want = cipher_due.pop_front();
        if (out_char !== want.ch) begin
          $display("%0t: out_char mismatch: expected %0d, actual %0d",
                   $time, want.ch, out_char);
          errors++;
        end
        if (out_invalid !== want.invalid) begin
          $display("%0t: out_invalid mismatch: expected %0b, actual %0b",
                   $time, want.invalid, out_invalid);
          errors++;
        end
      end
      words_checked++;
    end
    if (rst || in_taken || out_taken || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d words still due",
                 $time, idle_cycles, cipher_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Input driver. A word stays on the port until it is taken; after that a fresh
  // wait is drawn before the next one. Calm stretches with no gaps come and go.
  always @(negedge clk) begin : feed
    logic        drive_next;
    plain_word_t word;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      drive_next = 1'b0;
      if (in_taken) begin
        if ($urandom_range(0, 39) == 0) begin
          in_calm = !in_calm;
        end
        in_hold = draw_wait(in_calm);
      end
      if (in_hold > 0) begin
        in_hold--;
      end else if (plain_pending.size() > 0 &&
                   !(plain_pending[0].drain && words_checked != words_accepted)) begin
        word = plain_pending.pop_front();
        drive_next = 1'b1;
        in_char <= word.ch;
        message_start <= word.reload;
      end
      in_valid <= drive_next;
    end
  end

  // Result side: ready drops for a freshly drawn number of cycles after each word.
  always @(negedge clk) begin : drain_side
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) begin
          out_calm = !out_calm;
        end
        out_hold = draw_wait(out_calm);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One register write. The valid line stays high across back to back writes and
  // is lowered by close_writes once the batch is done.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, val);
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_word(input char_t ch, input logic reload, input logic drain);
    plain_word_t word;
    word.ch = ch;
    word.reload = reload;
    word.drain = drain;
    plain_pending = {plain_pending, word};
    words_queued++;
  endtask

  // Block until every queued word has been sent and its result checked. Each word
  // yields exactly one result, so the block is idle from here on.
  task automatic settle();
    do @(negedge clk); while (words_checked != words_queued);
  endtask

  // Start positions lean toward the edges: zero, the last position, values above
  // the alphabet that the block must reduce, and positions just short of a wrap.
  function automatic cfg_data_t pick_start();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return cfg_data_t'(POS_LAST);
      2: return cfg_data_t'($urandom_range(89, 127));
      3: return cfg_data_t'($urandom_range(80, 88));
      default: return cfg_data_t'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic random_setup();
    write_reg(REG_ENCRYPT_MODE, cfg_data_t'($urandom_range(0, 1)));
    write_reg(REG_ROTOR_START_0, pick_start());
    write_reg(REG_ROTOR_START_1, pick_start());
    write_reg(REG_ROTOR_START_2, pick_start());
    write_reg(REG_ROTOR_START_3, pick_start());
    close_writes();
  endtask

  // Messages: each opens with a reload and carries mostly printable text, with the
  // odd raw byte and the odd stray reload mixed in. Now and then a word waits for
  // the block to run dry before it goes.
  task automatic run_messages(input int count);
    int    sent;
    int    len;
    char_t ch;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 60);
      for (int i = 0; i < len && sent < count; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          ch = char_t'($urandom_range(0, 255));
        end else begin
          ch = char_t'($urandom_range(ALPHA_LOW, ALPHA_HIGH));
        end
        queue_word(ch, (i == 0) || ($urandom_range(0, 99) == 0), $urandom_range(0, 59) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Straight out of reset: encrypt mode, rotors at zero without any reload.
    // Both alphabet edges, the bytes just outside them, and the byte extremes.
    queue_word(8'd0, 1'b0, 1'b0);
    queue_word(8'd32, 1'b0, 1'b0);
    queue_word(CHAR_LOW, 1'b0, 1'b0);
    queue_word(CHAR_HIGH, 1'b0, 1'b0);
    queue_word(8'd122, 1'b0, 1'b0);
    queue_word(8'd255, 1'b0, 1'b0);
    queue_word(8'd127, 1'b0, 1'b0);
    queue_word(8'd65, 1'b1, 1'b0);
    settle();

    // Every rotor at its last position: the first step wraps the whole odometer.
    write_reg(REG_ENCRYPT_MODE, 7'd1);
    write_reg(REG_ROTOR_START_0, cfg_data_t'(POS_LAST));
    write_reg(REG_ROTOR_START_1, cfg_data_t'(POS_LAST));
    write_reg(REG_ROTOR_START_2, cfg_data_t'(POS_LAST));
    write_reg(REG_ROTOR_START_3, cfg_data_t'(POS_LAST));
    close_writes();
    queue_word(CHAR_LOW, 1'b1, 1'b0);
    queue_word(CHAR_HIGH, 1'b0, 1'b0);
    queue_word(8'd100, 1'b0, 1'b0);
    settle();

    // Decrypt with start values past the alphabet, which load reduced.
    write_reg(REG_ENCRYPT_MODE, 7'd0);
    write_reg(REG_ROTOR_START_0, 7'd127);
    write_reg(REG_ROTOR_START_1, 7'd89);
    write_reg(REG_ROTOR_START_2, 7'd100);
    write_reg(REG_ROTOR_START_3, 7'd127);
    close_writes();
    queue_word(CHAR_LOW, 1'b1, 1'b0);
    queue_word(CHAR_HIGH, 1'b0, 1'b0);
    queue_word(8'd200, 1'b0, 1'b0);
    queue_word(8'd77, 1'b0, 1'b0);
    settle();

    // The fast rotor wraps on the second word and the carry ripples upward.
    write_reg(REG_ROTOR_START_0, 7'd87);
    write_reg(REG_ROTOR_START_1, cfg_data_t'(POS_LAST));
    write_reg(REG_ROTOR_START_2, 7'd0);
    close_writes();
    queue_word(8'd50, 1'b1, 1'b0);
    queue_word(8'd51, 1'b0, 1'b0);
    queue_word(8'd52, 1'b0, 1'b0);
    queue_word(8'd53, 1'b0, 1'b0);
    settle();

    // Random phases, each under a fresh configuration written while the block is idle.
    repeat (8) begin
      random_setup();
      run_messages(135);
      settle();
    end

    repeat (8) @(posedge clk);
    if (cipher_due.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, cipher_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
